FILE: sv/oms_pkg.sv
// Shared constants, CORDIC arctangent table and pipeline bundle types
// for the odometry motion sampler. No dependencies.
package oms_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int VEC_W            = 52;  // vectoring datapath, holds 2^16 * |d| * gain
  localparam int ROT_W            = 34;  // rotation datapath, Q1.30 plus growth
  localparam int SQRT_STEPS       = 32;  // one result bit per stage for a 64-bit radicand
  localparam int GAIN_W           = 16;
  localparam int CFG_IDX_W        = 8;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd51;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_ROT_FROM_ROT     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_FROM_TRANS   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TRANS_FROM_TRANS = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TRANS_FROM_ROT   = 8'd3;

  localparam logic [29:0] INV_GAIN_Q30     = 30'd652032874;
  localparam logic [30:0] PI_OVER_8_Q32    = 31'd1686629713;
  localparam logic [29:0] TURN_PER_RAD_Q16 = 30'd683565276;

  // atan(2^-i) in 2^32 units per turn
  localparam logic [31:0] ATAN_TAB [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000
  };

  typedef struct packed {
    logic signed [VEC_W-1:0] x;     // scaled length before gain correction
    logic [31:0]             ang;   // heading of the displacement
    logic                    zero;  // displacement was zero
  } vec_out_t;

  typedef struct packed {
    logic signed [ROT_W-1:0] c;     // cosine before half-turn correction
    logic signed [ROT_W-1:0] s;     // sine before half-turn correction
    logic                    flip;  // negate both
  } rot_out_t;

  // Per-item context carried alongside the arithmetic
  typedef struct packed {
    logic [31:0] px;
    logic [31:0] py;
    logic [15:0] pyaw;
    logic [15:0] prev_yaw;
    logic [15:0] curr_yaw;
    logic [15:0] n1;
    logic [15:0] nt;
    logic [15:0] n2;
    logic [31:0] d1;
    logic [31:0] d2;
    logic [34:0] odo_len;
    logic [39:0] travel;
    logic [31:0] yaw;
  } ctx_t;

endpackage

FILE: sv/oms_dly.sv
// Enable-gated delay line used to carry item context past fixed-latency units.
// Depends on nothing.
module oms_dly #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] d_in,
  output logic [WIDTH-1:0] d_out
);

  logic [WIDTH-1:0] tap_r [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      tap_r[0] <= d_in;
    end
  end

  for (genvar k = 1; k < DEPTH; k++) begin : g_tap
    always_ff @(posedge clk) begin
      if (en) begin
        tap_r[k] <= tap_r[k-1];
      end
    end
  end

  assign d_out = tap_r[DEPTH-1];

endmodule

FILE: sv/oms_vec.sv
// Pipelined vectoring CORDIC: heading and scaled length of a displacement.
// Depends on oms_pkg. The folded input is registered, then every iteration is registered.
module oms_vec import oms_pkg::*; #(
  parameter int STEPS = CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [32:0] dx,
  input  logic signed [32:0] dy,
  output vec_out_t           vec_out
);

  localparam int N = (STEPS > 32) ? 32 : STEPS;

  logic signed [VEC_W-1:0] x_r [N+1];
  logic signed [VEC_W-1:0] y_r [N+1];
  logic [31:0]             a_r [N+1];
  logic                    z_r [N+1];
  logic signed [VEC_W-1:0] x0, y0;

  assign x0 = {{(VEC_W-49){dx[32]}}, dx, 16'b0};
  assign y0 = {{(VEC_W-49){dy[32]}}, dy, 16'b0};

  // Fold the left half-plane over so the iterations start with x >= 0
  always_ff @(posedge clk) begin
    if (en) begin
      z_r[0] <= (dx == '0) && (dy == '0);
      if (dx[32]) begin
        x_r[0] <= -x0;
        y_r[0] <= -y0;
        a_r[0] <= 32'h8000_0000;
      end else begin
        x_r[0] <= x0;
        y_r[0] <= y0;
        a_r[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    logic signed [VEC_W-1:0] xs, ys;
    assign xs = x_r[i] >>> i;
    assign ys = y_r[i] >>> i;
    always_ff @(posedge clk) begin
      if (en) begin
        z_r[i+1] <= z_r[i];
        if (y_r[i][VEC_W-1]) begin
          x_r[i+1] <= x_r[i] - ys;
          y_r[i+1] <= y_r[i] + xs;
          a_r[i+1] <= a_r[i] - ATAN_TAB[i];
        end else begin
          x_r[i+1] <= x_r[i] + ys;
          y_r[i+1] <= y_r[i] - xs;
          a_r[i+1] <= a_r[i] + ATAN_TAB[i];
        end
      end
    end
  end

  always_comb begin
    vec_out.x    = x_r[N];
    vec_out.ang  = z_r[N] ? 32'd0 : a_r[N];
    vec_out.zero = z_r[N];
  end

endmodule

FILE: sv/oms_rot.sv
// Pipelined rotation CORDIC: cosine and sine of a binary angle in Q1.30.
// Depends on oms_pkg. The folded angle is registered, then every iteration is registered.
module oms_rot import oms_pkg::*; #(
  parameter int STEPS = CORDIC_STEPS_DEF
) (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] phi,
  output rot_out_t    rot_out
);

  localparam int N = (STEPS > 32) ? 32 : STEPS;

  logic signed [ROT_W-1:0] x_r [N+1];
  logic signed [ROT_W-1:0] y_r [N+1];
  logic signed [ROT_W-1:0] z_r [N+1];
  logic                    f_r [N+1];
  logic                    flip;
  logic [31:0]             phi_f;

  // Second and third quadrants: rotate by a half turn, negate at the end
  assign flip  = phi[31] ^ phi[30];
  assign phi_f = flip ? (phi ^ 32'h8000_0000) : phi;

  always_ff @(posedge clk) begin
    if (en) begin
      f_r[0] <= flip;
      x_r[0] <= ROT_W'(INV_GAIN_Q30);
      y_r[0] <= '0;
      z_r[0] <= {{(ROT_W-32){phi_f[31]}}, phi_f};
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    logic signed [ROT_W-1:0] xs, ys, at;
    assign xs = x_r[i] >>> i;
    assign ys = y_r[i] >>> i;
    assign at = {{(ROT_W-32){1'b0}}, ATAN_TAB[i]};
    always_ff @(posedge clk) begin
      if (en) begin
        f_r[i+1] <= f_r[i];
        if (!z_r[i][ROT_W-1]) begin
          x_r[i+1] <= x_r[i] - ys;
          y_r[i+1] <= y_r[i] + xs;
          z_r[i+1] <= z_r[i] - at;
        end else begin
          x_r[i+1] <= x_r[i] + ys;
          y_r[i+1] <= y_r[i] - xs;
          z_r[i+1] <= z_r[i] + at;
        end
      end
    end
  end

  always_comb begin
    rot_out.c    = x_r[N];
    rot_out.s    = y_r[N];
    rot_out.flip = f_r[N];
  end

endmodule

FILE: sv/oms_isqrt.sv
// Pipelined integer square root of a 64-bit value, one result bit per stage.
// Depends on oms_pkg. Every stage is registered.
module oms_isqrt import oms_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] v_in,
  output logic [31:0] root
);

  logic [63:0] v_r [SQRT_STEPS];
  logic [63:0] r_r [SQRT_STEPS];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_it
    localparam logic [63:0] BIT = 64'd1 << (62 - 2*k);
    logic [63:0] vp, rp, trial;
    if (k == 0) begin : g_first
      assign vp = v_in;
      assign rp = '0;
    end else begin : g_next
      assign vp = v_r[k-1];
      assign rp = r_r[k-1];
    end
    assign trial = rp + BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        if (vp >= trial) begin
          v_r[k] <= vp - trial;
          r_r[k] <= (rp >> 1) + BIT;
        end else begin
          v_r[k] <= vp;
          r_r[k] <= rp >> 1;
        end
      end
    end
  end

  assign root = r_r[SQRT_STEPS-1][31:0];

endmodule

FILE: sv/odometry_motion_sample_top.sv
// Odometry motion sampler, top level. Uses oms_pkg, oms_dly, oms_vec, oms_isqrt, oms_rot.
// Streams one particle update per transfer through a fully pipelined datapath.
//
// One particle enters per clock and one sampled pose leaves per clock while out_tready
// does not hold the pipeline. Each transfer passes two CORDIC pipelines of
// min(CORDIC_STEPS,32)+1 stages, a 32-stage square root pipeline (one root bit per stage)
// and 14 stages of multiply, round and saturate logic.
// The whole pipeline advances together: when a result sits in the output register and
// out_tready is low, every stage holds and in_tready drops; nothing is dropped or
// repeated. The gain registers hold Q8.8 alpha values, reset to 51, and take effect on
// items that reach S5 after the write; write them only while the pipeline is empty.
// Register indexes above 3 are ignored. No clearing pass is needed after reset.
module odometry_motion_sample_top import oms_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration write port
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [GAIN_W-1:0]    cfg_wdata,
  // input stream
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // lowest bit up: odom_prev_x, odom_prev_y, odom_prev_yaw, odom_curr_x, odom_curr_y,
  // odom_curr_yaw, particle_x, particle_y, particle_yaw, noise_first_turn,
  // noise_travel, noise_second_turn
  input  logic [287:0]         in_tdata,
  // result stream
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // lowest bit up: new_pose_x, new_pose_y, new_pose_yaw
  output logic [79:0]          out_tdata
);

  localparam int N   = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
  localparam int LAT = 2*(N+1) + SQRT_STEPS + 14;

  // ---------------------------------------------------------------------------
  // Helpers
  // ---------------------------------------------------------------------------
  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
  endfunction

  // floor(alpha * term / 256), saturating, from the split products
  function automatic logic [63:0] gain_combine(input logic [71:0] mh, input logic [23:0] ml);
    logic [63:0] r;
    if (mh[71:64] != '0) begin
      r = 64'hFFFF_FFFF_FFFF_FFFF;
    end else begin
      r = sat_add(mh[63:0], {48'b0, ml[23:8]});
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------
  logic [GAIN_W-1:0] g_rr_r, g_rt_r, g_tt_r, g_tr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_rr_r <= GAIN_RESET;
      g_rt_r <= GAIN_RESET;
      g_tt_r <= GAIN_RESET;
      g_tr_r <= GAIN_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_ROT_FROM_ROT:     g_rr_r <= cfg_wdata;
        REG_ROT_FROM_TRANS:   g_rt_r <= cfg_wdata;
        REG_TRANS_FROM_TRANS: g_tt_r <= cfg_wdata;
        REG_TRANS_FROM_ROT:   g_tr_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Flow control: one valid bit per stage, all stages advance together
  // ---------------------------------------------------------------------------
  logic           en;
  logic [LAT-1:0] vld_r;

  assign en         = !vld_r[LAT-1] || out_tready;
  assign in_tready  = en;
  assign out_tvalid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_tvalid};
    end
  end

  // ---------------------------------------------------------------------------
  // S0: capture the transfer, form the odometry displacement
  // ---------------------------------------------------------------------------
  logic signed [32:0] dx0_r, dy0_r;
  ctx_t               ctx0_nxt, ctx0_r;

  always_comb begin
    ctx0_nxt          = '0;
    ctx0_nxt.prev_yaw = in_tdata[79:64];
    ctx0_nxt.curr_yaw = in_tdata[159:144];
    ctx0_nxt.px       = in_tdata[191:160];
    ctx0_nxt.py       = in_tdata[223:192];
    ctx0_nxt.pyaw     = in_tdata[239:224];
    ctx0_nxt.n1       = in_tdata[255:240];
    ctx0_nxt.nt       = in_tdata[271:256];
    ctx0_nxt.n2       = in_tdata[287:272];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx0_r  <= $signed({in_tdata[111], in_tdata[111:80]})
              - $signed({in_tdata[31], in_tdata[31:0]});
      dy0_r  <= $signed({in_tdata[143], in_tdata[143:112]})
              - $signed({in_tdata[63], in_tdata[63:32]});
      ctx0_r <= ctx0_nxt;
    end
  end

  // Heading and length of the displacement
  vec_out_t vec_out;
  ctx_t     ctx_v;

  oms_vec #(.STEPS(CORDIC_STEPS)) u_vec (
    .clk     (clk),
    .en      (en),
    .dx      (dx0_r),
    .dy      (dy0_r),
    .vec_out (vec_out)
  );

  oms_dly #(.WIDTH($bits(ctx_t)), .DEPTH(N+1)) u_dly_vec (
    .clk   (clk),
    .en    (en),
    .d_in  (ctx0_r),
    .d_out (ctx_v)
  );

  // ---------------------------------------------------------------------------
  // S1: gain-correction products for the length, split turn deltas
  // ---------------------------------------------------------------------------
  logic [VEC_W-1:0] xpos;
  logic [31:0]      d1_nxt;
  logic [49:0]      hi1_r;
  logic [61:0]      lo1_r;
  logic             z1_r;
  ctx_t             ctx1_nxt, ctx1_r;

  assign xpos   = (!vec_out.zero && vec_out.x > 0) ? vec_out.x : '0;
  assign d1_nxt = vec_out.ang - {ctx_v.prev_yaw, 16'b0};

  always_comb begin
    ctx1_nxt    = ctx_v;
    ctx1_nxt.d1 = d1_nxt;
    ctx1_nxt.d2 = {ctx_v.curr_yaw, 16'b0} - {ctx_v.prev_yaw, 16'b0} - d1_nxt;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hi1_r  <= 50'(xpos[VEC_W-1:32] * INV_GAIN_Q30);
      lo1_r  <= xpos[31:0] * INV_GAIN_Q30;
      z1_r   <= vec_out.zero;
      ctx1_r <= ctx1_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // S2: round the length, convert turn deltas toward radians
  // ---------------------------------------------------------------------------
  logic [50:0]        len_sum;
  logic signed [63:0] p1_r, p2_r;
  ctx_t               ctx2_nxt, ctx2_r;

  assign len_sum = {1'b0, hi1_r} + {21'b0, lo1_r[61:32]} + 51'd8192;

  always_comb begin
    ctx2_nxt         = ctx1_r;
    ctx2_nxt.odo_len = len_sum[48:14];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx2_r <= ctx2_nxt;
      p1_r   <= $signed(ctx1_r.d1) * $signed({1'b0, PI_OVER_8_Q32});
      p2_r   <= $signed(ctx1_r.d2) * $signed({1'b0, PI_OVER_8_Q32});
    end
  end

  // ---------------------------------------------------------------------------
  // S3: radians in Q3.28, squared travel
  // ---------------------------------------------------------------------------
  logic [63:0]        p1_rnd, p2_rnd;
  logic signed [30:0] r1_r, r2_r;
  logic [63:0]        tt3_r;
  ctx_t               ctx3_r;

  assign p1_rnd = p1_r + 64'sd2147483648;
  assign p2_rnd = p2_r + 64'sd2147483648;

  always_ff @(posedge clk) begin
    if (en) begin
      ctx3_r <= ctx2_r;
      r1_r   <= p1_rnd[62:32];
      r2_r   <= p2_rnd[62:32];
      if (ctx2_r.odo_len[34:32] != '0) begin
        tt3_r <= 64'hFFFF_FFFF_FFFF_FFFF;
      end else begin
        tt3_r <= ctx2_r.odo_len[31:0] * ctx2_r.odo_len[31:0];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // S4: squared turns
  // ---------------------------------------------------------------------------
  logic [30:0] m1, m2;
  logic [61:0] sq1, sq2;
  logic [37:0] q1_r, q2_r;
  logic [63:0] tt4_r;
  ctx_t        ctx4_r;

  assign m1  = r1_r[30] ? 31'(-r1_r) : r1_r;
  assign m2  = r2_r[30] ? 31'(-r2_r) : r2_r;
  assign sq1 = m1 * m1;
  assign sq2 = m2 * m2;

  always_ff @(posedge clk) begin
    if (en) begin
      ctx4_r <= ctx3_r;
      q1_r   <= sq1[61:24];
      q2_r   <= sq2[61:24];
      tt4_r  <= tt3_r;
    end
  end

  // ---------------------------------------------------------------------------
  // S5: alpha-weighted products, split at the Q8.8 point
  // ---------------------------------------------------------------------------
  logic [38:0] qs;
  logic [71:0] mh_a_r, mh_b_r, mh_c_r, mh_d_r, mh_e_r;
  logic [23:0] ml_a_r, ml_b_r, ml_c_r, ml_d_r, ml_e_r;
  ctx_t        ctx5_r;

  assign qs = {1'b0, q1_r} + {1'b0, q2_r};

  always_ff @(posedge clk) begin
    if (en) begin
      ctx5_r <= ctx4_r;
      mh_a_r <= g_rr_r * {26'b0, q1_r[37:8]};
      ml_a_r <= g_rr_r * q1_r[7:0];
      mh_b_r <= g_rt_r * {8'b0, tt4_r[63:8]};
      ml_b_r <= g_rt_r * tt4_r[7:0];
      mh_c_r <= g_tt_r * {8'b0, tt4_r[63:8]};
      ml_c_r <= g_tt_r * tt4_r[7:0];
      mh_d_r <= g_tr_r * {25'b0, qs[38:8]};
      ml_d_r <= g_tr_r * qs[7:0];
      mh_e_r <= g_rr_r * {26'b0, q2_r[37:8]};
      ml_e_r <= g_rr_r * q2_r[7:0];
    end
  end

  // ---------------------------------------------------------------------------
  // S6: saturate each weighted term
  // ---------------------------------------------------------------------------
  logic [63:0] sg_a_r, sg_b_r, sg_c_r, sg_d_r, sg_e_r;
  ctx_t        ctx6_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ctx6_r <= ctx5_r;
      sg_a_r <= gain_combine(mh_a_r, ml_a_r);
      sg_b_r <= gain_combine(mh_b_r, ml_b_r);
      sg_c_r <= gain_combine(mh_c_r, ml_c_r);
      sg_d_r <= gain_combine(mh_d_r, ml_d_r);
      sg_e_r <= gain_combine(mh_e_r, ml_e_r);
    end
  end

  // ---------------------------------------------------------------------------
  // S7: variances of first turn, travel and second turn
  // ---------------------------------------------------------------------------
  logic [63:0] v1_r, vt_r, v2_r;
  ctx_t        ctx7_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ctx7_r <= ctx6_r;
      v1_r   <= sat_add(sg_a_r, sg_b_r);
      vt_r   <= sat_add(sg_c_r, sg_d_r);
      v2_r   <= sat_add(sg_e_r, sg_b_r);
    end
  end

  // Standard deviations
  logic [31:0] sd1, sdt, sd2;
  ctx_t        ctx_q;

  oms_isqrt u_sqrt_1 (.clk(clk), .en(en), .v_in(v1_r), .root(sd1));
  oms_isqrt u_sqrt_t (.clk(clk), .en(en), .v_in(vt_r), .root(sdt));
  oms_isqrt u_sqrt_2 (.clk(clk), .en(en), .v_in(v2_r), .root(sd2));

  oms_dly #(.WIDTH($bits(ctx_t)), .DEPTH(SQRT_STEPS)) u_dly_sqrt (
    .clk   (clk),
    .en    (en),
    .d_in  (ctx7_r),
    .d_out (ctx_q)
  );

  // ---------------------------------------------------------------------------
  // S8: scale the noise samples, round at Q4.12
  // ---------------------------------------------------------------------------
  logic signed [48:0] pr1, prt, pr2;
  logic signed [36:0] pe1_r, pet_r, pe2_r;
  ctx_t               ctx8_r;

  assign pr1 = $signed(ctx_q.n1) * $signed({1'b0, sd1}) + 49'sd2048;
  assign prt = $signed(ctx_q.nt) * $signed({1'b0, sdt}) + 49'sd2048;
  assign pr2 = $signed(ctx_q.n2) * $signed({1'b0, sd2}) + 49'sd2048;

  always_ff @(posedge clk) begin
    if (en) begin
      ctx8_r <= ctx_q;
      pe1_r  <= pr1[48:12];
      pet_r  <= prt[48:12];
      pe2_r  <= pr2[48:12];
    end
  end

  // ---------------------------------------------------------------------------
  // S9: perturbed travel, radian-to-turn products
  // ---------------------------------------------------------------------------
  logic [47:0] pw1, pw2;
  logic [61:0] tl1_r, tl2_r;
  logic [15:0] th1_r, th2_r;
  ctx_t        ctx9_nxt, ctx9_r;

  assign pw1 = {{11{pe1_r[36]}}, pe1_r};
  assign pw2 = {{11{pe2_r[36]}}, pe2_r};

  always_comb begin
    ctx9_nxt        = ctx8_r;
    ctx9_nxt.travel = $signed({5'b0, ctx8_r.odo_len}) - $signed({{3{pet_r[36]}}, pet_r});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx9_r <= ctx9_nxt;
      tl1_r  <= pw1[31:0] * TURN_PER_RAD_Q16;
      tl2_r  <= pw2[31:0] * TURN_PER_RAD_Q16;
      th1_r  <= 16'(pw1[47:32] * TURN_PER_RAD_Q16);
      th2_r  <= 16'(pw2[47:32] * TURN_PER_RAD_Q16);
    end
  end

  // ---------------------------------------------------------------------------
  // S10: perturbed turns
  // ---------------------------------------------------------------------------
  logic [47:0] ts1, ts2;
  logic [31:0] d1h_r, d2h_r;
  ctx_t        ctx10_r;

  assign ts1 = tl1_r[47:0] + {th1_r, 32'b0} + 48'h8000;
  assign ts2 = tl2_r[47:0] + {th2_r, 32'b0} + 48'h8000;

  always_ff @(posedge clk) begin
    if (en) begin
      ctx10_r <= ctx9_r;
      d1h_r   <= ctx9_r.d1 - ts1[47:16];
      d2h_r   <= ctx9_r.d2 - ts2[47:16];
    end
  end

  // ---------------------------------------------------------------------------
  // S11: new heading after the first turn and after the second
  // ---------------------------------------------------------------------------
  logic [31:0] phi_nxt, phi11_r;
  ctx_t        ctx11_nxt, ctx11_r;

  assign phi_nxt = {ctx10_r.pyaw, 16'b0} + d1h_r;

  always_comb begin
    ctx11_nxt     = ctx10_r;
    ctx11_nxt.yaw = phi_nxt + d2h_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      phi11_r <= phi_nxt;
      ctx11_r <= ctx11_nxt;
    end
  end

  rot_out_t rot_out;
  ctx_t     ctx_r;

  oms_rot #(.STEPS(CORDIC_STEPS)) u_rot (
    .clk     (clk),
    .en      (en),
    .phi     (phi11_r),
    .rot_out (rot_out)
  );

  oms_dly #(.WIDTH($bits(ctx_t)), .DEPTH(N+1)) u_dly_rot (
    .clk   (clk),
    .en    (en),
    .d_in  (ctx11_r),
    .d_out (ctx_r)
  );

  // ---------------------------------------------------------------------------
  // S12: travel times cosine and sine, on magnitudes
  // ---------------------------------------------------------------------------
  logic [39:0]        tmag;
  logic [ROT_W-1:0]   cmag, smag;
  logic               tneg, cneg, sneg;
  logic [ROT_W+6:0]   hx_r, hy_r;
  logic [ROT_W+31:0]  lx_r, ly_r;
  logic               negx_r, negy_r;
  ctx_t               ctx12_r;

  assign tneg = ctx_r.travel[39];
  assign tmag = tneg ? 40'(-$signed(ctx_r.travel)) : ctx_r.travel;
  assign cmag = rot_out.c[ROT_W-1] ? ROT_W'(-rot_out.c) : rot_out.c;
  assign smag = rot_out.s[ROT_W-1] ? ROT_W'(-rot_out.s) : rot_out.s;
  assign cneg = rot_out.flip ? (rot_out.c > 0) : rot_out.c[ROT_W-1];
  assign sneg = rot_out.flip ? (rot_out.s > 0) : rot_out.s[ROT_W-1];

  always_ff @(posedge clk) begin
    if (en) begin
      ctx12_r <= ctx_r;
      hx_r    <= tmag[38:32] * cmag;
      lx_r    <= tmag[31:0] * cmag;
      hy_r    <= tmag[38:32] * smag;
      ly_r    <= tmag[31:0] * smag;
      negx_r  <= tneg ^ cneg;
      negy_r  <= tneg ^ sneg;
    end
  end

  // ---------------------------------------------------------------------------
  // S13: round at 2^30, apply sign, add to particle, saturate; output register
  // ---------------------------------------------------------------------------
  logic [ROT_W+32:0]  lx_rnd, ly_rnd;
  logic [43:0]        mx, my;
  logic signed [45:0] sx, sy;
  logic [31:0]        yaw_rnd;
  logic [31:0]        out_x_r, out_y_r;
  logic [15:0]        out_yaw_r;

  assign lx_rnd  = {1'b0, lx_r} + (ROT_W+33)'(1 << 29);
  assign ly_rnd  = {1'b0, ly_r} + (ROT_W+33)'(1 << 29);
  assign mx      = 44'({hx_r, 2'b0}) + 44'(lx_rnd[ROT_W+32:30]);
  assign my      = 44'({hy_r, 2'b0}) + 44'(ly_rnd[ROT_W+32:30]);
  assign sx      = $signed({{14{ctx12_r.px[31]}}, ctx12_r.px})
                 + (negx_r ? -$signed({2'b0, mx}) : $signed({2'b0, mx}));
  assign sy      = $signed({{14{ctx12_r.py[31]}}, ctx12_r.py})
                 + (negy_r ? -$signed({2'b0, my}) : $signed({2'b0, my}));
  assign yaw_rnd = ctx12_r.yaw + 32'h8000;

  always_ff @(posedge clk) begin
    if (en) begin
      if (sx > 46'sd2147483647) begin
        out_x_r <= 32'h7FFF_FFFF;
      end else if (sx < -46'sd2147483648) begin
        out_x_r <= 32'h8000_0000;
      end else begin
        out_x_r <= sx[31:0];
      end
      if (sy > 46'sd2147483647) begin
        out_y_r <= 32'h7FFF_FFFF;
      end else if (sy < -46'sd2147483648) begin
        out_y_r <= 32'h8000_0000;
      end else begin
        out_y_r <= sy[31:0];
      end
      out_yaw_r <= yaw_rnd[31:16];
    end
  end

  assign out_tdata = {out_yaw_r, out_y_r, out_x_r};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_reset_empties: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> vld_r[0])
    else $error("accepted transfer did not enter the pipeline");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("pipeline moved while stalled");

  a_zero_length: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[N+1] && z1_r) |-> (hi1_r == '0 && lo1_r == '0))
    else $error("zero displacement gave nonzero length products");

endmodule

FILE: tb/sv/odometry_motion_sample_top_tb.sv
// Self-checking testbench for odometry_motion_sample_top: directed table, then randomized
// phases under several gain settings. Depends on oms_pkg and the top level only.
module odometry_motion_sample_top_tb;
  import oms_pkg::*;

  localparam int LATENCY     = 2 * CORDIC_STEPS_DEF + 48;
  localparam int CYCLE_LIMIT = 600000;
  localparam int RAND_ITEMS  = 190;   // per gain setting, five settings

  typedef struct packed {
    logic [15:0] n2;
    logic [15:0] nt;
    logic [15:0] n1;
    logic [15:0] part_yaw;
    logic [31:0] part_y;
    logic [31:0] part_x;
    logic [15:0] curr_yaw;
    logic [31:0] curr_y;
    logic [31:0] curr_x;
    logic [15:0] prev_yaw;
    logic [31:0] prev_y;
    logic [31:0] prev_x;
  } odom_item_t;

  typedef struct packed {
    logic [15:0] yaw;
    logic [31:0] y;
    logic [31:0] x;
  } pose_t;

  typedef struct {
    odom_item_t item;
    bit         known;   // pose typed in below, else taken from the predictor
    pose_t      pose;
  } table_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [GAIN_W-1:0]    cfg_wdata = '0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [287:0]         in_tdata = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [79:0]          out_tdata;

  logic [GAIN_W-1:0] alpha [4];   // shadow of the gain registers
  pose_t             pose_q [$];  // expected sampled poses, oldest first
  bit                row_known = 1'b0;
  pose_t             row_pose;
  int                mismatches = 0;
  longint            cycles = 0;

  odometry_motion_sample_top dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------------------
  // Pose predictor, fixed point throughout
  // ---------------------------------------------------------------------------------------
  function automatic longint unsigned round_shift_mul(longint unsigned a, longint unsigned b,
                                                      int s);
    bit [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    p = p + (128'd1 << (s - 1));
    return 64'(p >> s);
  endfunction

  function automatic longint unsigned add_clip(longint unsigned a, longint unsigned b);
    bit [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
  endfunction

  function automatic longint unsigned weigh(logic [15:0] g, longint unsigned term);
    bit [127:0] v;
    v = {112'd0, g} * {64'd0, term >> 8} + (({112'd0, g} * {120'd0, term[7:0]}) >> 8);
    return (v[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : v[63:0];
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint turn_to_rad_sq(logic [31:0] d);
    longint r;
    longint unsigned m;
    r = (longint'(signed'(d)) * longint'(PI_OVER_8_Q32) + 64'sd2147483648) >>> 32;
    m = (r < 0) ? -r : r;
    return (m * m) >> 24;
  endfunction

  function automatic longint noise_offset(logic [15:0] n, longint unsigned sd);
    return (longint'(signed'(n)) * longint'(sd) + 2048) >>> 12;
  endfunction

  function automatic logic [31:0] rad_to_angle(longint p);
    bit [63:0] t;
    t = 64'(p) * 64'(TURN_PER_RAD_Q16) + 64'h8000;
    return t[47:16];
  endfunction

  function automatic longint travel_part(longint len, longint trig);
    longint unsigned ml, mt;
    longint m;
    ml = (len < 0) ? -len : len;
    mt = (trig < 0) ? -trig : trig;
    m = round_shift_mul(ml, mt, 30);
    return ((len < 0) != (trig < 0)) ? -m : m;
  endfunction

  function automatic logic [31:0] clip32(longint v);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  function automatic pose_t predict_pose(odom_item_t it);
    longint dx, dy, x, y, xs, ys, z, c, s, travel;
    logic [31:0] heading, d1, d2, d1h, d2h, phi, yaw, prev_a;
    longint unsigned odo_len, q1, q2, tt, v1, vt, v2;
    bit flip;
    int n;
    pose_t r;
    n = (CORDIC_STEPS_DEF > 32) ? 32 : CORDIC_STEPS_DEF;
    dx = longint'(signed'(it.curr_x)) - longint'(signed'(it.prev_x));
    dy = longint'(signed'(it.curr_y)) - longint'(signed'(it.prev_y));
    // heading and length of the odometry displacement
    heading = 0;
    odo_len = 0;
    if (dx != 0 || dy != 0) begin
      x = dx * 65536;
      y = dy * 65536;
      if (x < 0) begin
        x = -x;
        y = -y;
        heading = 32'h8000_0000;
      end
      for (int i = 0; i < n; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y < 0) begin
          x -= ys; y += xs; heading -= ATAN_TAB[i];
        end else begin
          x += ys; y -= xs; heading += ATAN_TAB[i];
        end
      end
      odo_len = (x > 0) ? round_shift_mul(x, INV_GAIN_Q30, 46) : 0;
    end
    prev_a = {it.prev_yaw, 16'd0};
    d1 = heading - prev_a;
    d2 = {it.curr_yaw, 16'd0} - prev_a - d1;
    q1 = turn_to_rad_sq(d1);
    q2 = turn_to_rad_sq(d2);
    tt = (odo_len > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF_FFFF_FFFF : odo_len * odo_len;
    v1 = add_clip(weigh(alpha[0], q1), weigh(alpha[1], tt));
    vt = add_clip(weigh(alpha[2], tt), weigh(alpha[3], add_clip(q1, q2)));
    v2 = add_clip(weigh(alpha[0], q2), weigh(alpha[1], tt));
    d1h = d1 - rad_to_angle(noise_offset(it.n1, root_floor(v1)));
    travel = longint'(odo_len) - noise_offset(it.nt, root_floor(vt));
    d2h = d2 - rad_to_angle(noise_offset(it.n2, root_floor(v2)));
    // move the particle along its perturbed heading
    phi = {it.part_yaw, 16'd0} + d1h;
    flip = (phi[31:30] == 2'b01) || (phi[31:30] == 2'b10);
    z = longint'(signed'(flip ? phi - 32'h8000_0000 : phi));
    c = INV_GAIN_Q30;
    s = 0;
    for (int i = 0; i < n; i++) begin
      xs = c >>> i;
      ys = s >>> i;
      if (z >= 0) begin
        c -= ys; s += xs; z -= ATAN_TAB[i];
      end else begin
        c += ys; s -= xs; z += ATAN_TAB[i];
      end
    end
    if (flip) begin
      c = -c;
      s = -s;
    end
    r.x = clip32(longint'(signed'(it.part_x)) + travel_part(travel, c));
    r.y = clip32(longint'(signed'(it.part_y)) + travel_part(travel, s));
    yaw = phi + d2h + 32'h8000;
    r.yaw = yaw[31:16];
    return r;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Expectation capture and result checking, both at the rising edge
  // ---------------------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      pose_q.push_back(row_known ? row_pose : predict_pose(odom_item_t'(in_tdata)));
  end

  always @(posedge clk) begin
    pose_t want, got;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (pose_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected pose out: %h", got);
      end else begin
        want = pose_q.pop_front();
        if (want !== got) begin
          mismatches++;
          if (mismatches <= 10)
            $display("pose mismatch: x exp %h got %h, y exp %h got %h, yaw exp %h got %h",
                     want.x, got.x, want.y, got.y, want.yaw, got.yaw);
        end
      end
    end
  end

  // Hard stop in case the handshake locks up
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver backpressure: mostly ready, short stalls, the odd long one
  initial begin
    int g;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      out_tready = 1'b1;
      repeat ($urandom_range(0, 15)) @(negedge clk);
      if ($urandom_range(0, 2) == 0) begin
        g = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
        out_tready = 1'b0;
        repeat (g) @(negedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------------------
  // Present one item and hold it until the transfer happens.
  task automatic push_item(odom_item_t it, bit known, pose_t p);
    @(negedge clk);
    in_tdata  = it;
    row_known = known;
    row_pose  = p;
    in_tvalid = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Drop valid for a random gap, often none so back-to-back transfers occur.
  task automatic sender_gap();
    int g;
    if ($urandom_range(0, 2) != 0) return;
    g = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
    @(negedge clk);
    in_tvalid = 1'b0;
    repeat (g - 1) @(negedge clk);
  endtask

  // Wait until every expected pose has arrived, then let the pipeline run dry.
  task automatic drain();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pose_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
  endtask

  task automatic write_gain(logic [CFG_IDX_W-1:0] idx, logic [GAIN_W-1:0] val);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    if (idx <= REG_TRANS_FROM_ROT) alpha[idx[1:0]] = val;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic set_gains(logic [15:0] a0, logic [15:0] a1, logic [15:0] a2,
                           logic [15:0] a3);
    write_gain(REG_ROT_FROM_ROT, a0);
    write_gain(REG_ROT_FROM_TRANS, a1);
    write_gain(REG_TRANS_FROM_TRANS, a2);
    write_gain(REG_TRANS_FROM_ROT, a3);
  endtask

  function automatic logic [31:0] rand_delta();
    int sh;
    sh = $urandom_range(0, 24);
    return ($urandom & ((32'd1 << sh) - 1)) * (($urandom_range(0, 1) != 0) ? -1 : 1);
  endfunction

  function automatic logic [15:0] rand_noise();
    if ($urandom_range(0, 7) == 0) return 16'($urandom);
    return 16'($signed($urandom_range(0, 16384)) - 8192);
  endfunction

  // Mostly plausible odometry steps with random content, some fully random items.
  function automatic odom_item_t rand_item();
    odom_item_t it;
    it = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
          $urandom};
    if ($urandom_range(0, 4) != 0) begin
      it.curr_x   = it.prev_x + rand_delta();
      it.curr_y   = it.prev_y + rand_delta();
      it.curr_yaw = it.prev_yaw + 16'(rand_delta() >> 12);
      it.n1 = rand_noise();
      it.nt = rand_noise();
      it.n2 = rand_noise();
    end
    return it;
  endfunction

  function automatic odom_item_t odom(logic [31:0] px0, logic [31:0] py0, logic [15:0] pa0,
                                      logic [31:0] px1, logic [31:0] py1, logic [15:0] pa1,
                                      logic [31:0] qx, logic [31:0] qy, logic [15:0] qa,
                                      logic [15:0] n1, logic [15:0] nt, logic [15:0] n2);
    odom_item_t it;
    it.prev_x = px0; it.prev_y = py0; it.prev_yaw = pa0;
    it.curr_x = px1; it.curr_y = py1; it.curr_yaw = pa1;
    it.part_x = qx;  it.part_y = qy;  it.part_yaw = qa;
    it.n1 = n1; it.nt = nt; it.n2 = n2;
    return it;
  endfunction

  initial begin
    table_row_t rows [$];
    table_row_t r;
    pose_t none;
    none = '0;
    alpha = '{GAIN_RESET, GAIN_RESET, GAIN_RESET, GAIN_RESET};

    // Without displacement and with zero noise the particle keeps its place and turns by
    // the odometry heading change, so those rows carry their pose typed in.
    r.known = 1;
    r.item = '0;                                                              r.pose = '0;
    rows.push_back(r);
    r.item = odom(0, 0, 16'h0000, 0, 0, 16'h0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h7FFF,
                  0, 0, 0);
    r.pose = '{yaw: 16'h7FFF, y: 32'h7FFF_FFFF, x: 32'h7FFF_FFFF};
    rows.push_back(r);
    r.item = odom(5, 5, 16'd100, 5, 5, 16'd300, 32'h8000_0000, 32'h8000_0000, 16'h8000,
                  0, 0, 0);
    r.pose = '{yaw: 16'h80C8, y: 32'h8000_0000, x: 32'h8000_0000};
    rows.push_back(r);
    r.item = odom(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h7FFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  16'h8000, 32'h1234_5678, 32'hFEDC_BA98, 16'hFFFF, 0, 0, 0);
    r.pose = '{yaw: 16'h0000, y: 32'hFEDC_BA98, x: 32'h1234_5678};
    rows.push_back(r);

    r.known = 0;
    r.pose = none;
    // zero displacement with extreme noise: only the turn variances count
    r.item = odom(0, 0, 16'h4000, 0, 0, 16'hC000, 0, 0, 0, 16'h7FFF, 16'h8000, 16'h7FFF);
    rows.push_back(r);
    // one metre along each axis, both signs
    r.item = odom(0, 0, 0, 32'h0001_0000, 0, 0, 0, 0, 0, 16'h1000, 16'hF000, 16'h0800);
    rows.push_back(r);
    r.item = odom(0, 0, 0, 32'hFFFF_0000, 0, 16'h8000, 0, 0, 0, 0, 16'h1000, 0);
    rows.push_back(r);
    r.item = odom(0, 0, 0, 0, 32'h0001_0000, 16'h4000, 0, 0, 16'h4000, 16'hF800, 0, 16'h0800);
    rows.push_back(r);
    r.item = odom(0, 0, 0, 0, 32'hFFFF_0000, 16'hC000, 0, 0, 16'hC000, 0, 0, 0);
    rows.push_back(r);
    r.item = odom(0, 0, 16'h2000, 32'h0003_0000, 32'h0003_0000, 16'h2000, 100, -100, 0,
                  16'h0400, 16'hFC00, 16'h0400);
    rows.push_back(r);
    // smallest step, one LSB
    r.item = odom(0, 0, 0, 1, 0, 0, 0, 0, 0, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    rows.push_back(r);
    // widest displacement corner to corner: variance saturates
    r.item = odom(32'h8000_0000, 32'h8000_0000, 16'h8000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  16'h7FFF, 0, 0, 0, 16'h7FFF, 16'h8000, 16'h8000);
    rows.push_back(r);
    r.item = odom(32'h7FFF_FFFF, 32'h8000_0000, 0, 32'h8000_0000, 32'h7FFF_FFFF, 0,
                  32'h7FFF_FFFF, 32'h8000_0000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
    rows.push_back(r);
    // strong positive travel noise drives the particle backward
    r.item = odom(0, 0, 0, 32'h0010_0000, 0, 0, 0, 0, 0, 0, 16'h7FFF, 0);
    rows.push_back(r);
    r.item = odom(0, 0, 0, 32'h0010_0000, 0, 0, 0, 0, 16'h8000, 0, 16'h7FFF, 0);
    rows.push_back(r);
    // position overflow both ways
    r.item = odom(0, 0, 0, 32'h0100_0000, 32'h0100_0000, 0, 32'h7FFF_0000, 32'h7FFF_0000,
                  16'h2000, 0, 16'hF000, 0);
    rows.push_back(r);
    r.item = odom(0, 0, 0, 32'h0100_0000, 32'h0100_0000, 0, 32'h8000_FFFF, 32'h8000_FFFF,
                  16'hA000, 0, 16'hF000, 0);
    rows.push_back(r);
    // heading right at the quadrant borders
    r.item = odom(0, 0, 16'h3FFF, 32'h0002_0000, 32'h0002_0000, 16'h4000, 0, 0, 16'h3FFF,
                  0, 0, 0);
    rows.push_back(r);
    r.item = odom(0, 0, 16'hBFFF, 32'hFFFE_0000, 32'h0002_0000, 16'h7FFF, 0, 0, 16'hC001,
                  16'h8000, 0, 16'h7FFF);
    rows.push_back(r);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (rows[i]) begin
      push_item(rows[i].item, rows[i].known, rows[i].pose);
      sender_gap();
    end
    drain();
    row_known = 1'b0;

    // Walk through gain settings, extremes included; stray indexes must not land.
    for (int ph = 0; ph < 5; ph++) begin
      unique case (ph)
        0: set_gains(16'd0, 16'd0, 16'd0, 16'd0);
        1: set_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        2: set_gains(GAIN_RESET, 16'd0, 16'hFFFF, 16'd1);
        default: set_gains(16'($urandom), 16'($urandom), 16'($urandom_range(0, 1024)),
                           16'($urandom));
      endcase
      write_gain(8'd4, 16'($urandom));
      write_gain(8'hFF, 16'($urandom));
      for (int k = 0; k < RAND_ITEMS; k++) begin
        push_item(rand_item(), 1'b0, none);
        sender_gap();
        // hold off once per gain setting, halfway through, until the pipeline has emptied
        if (k == RAND_ITEMS / 2) begin
          @(negedge clk);
          in_tvalid = 1'b0;
          while (pose_q.size() != 0) @(posedge clk);
        end
      end
      drain();
    end

    if (mismatches == 0 && pose_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/oms_pkg.sv
sv/oms_dly.sv
sv/oms_vec.sv
sv/oms_rot.sv
sv/oms_isqrt.sv
sv/odometry_motion_sample_top.sv
tb/sv/odometry_motion_sample_top_tb.sv
